/* sv/uca_pkg.sv */
package uca_pkg;

  // Longest sequence in the original six-byte UTF-8 form
  localparam int unsigned MAX_SEQ_LEN_DEF = 6;

  // Fixed field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CHAR_W = 48;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned POS_W  = 3;

  // Byte class boundaries
  localparam logic [BYTE_W-1:0] CONT_LO  = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD_LO  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD5_LO = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD6_LO = 8'hFC;
  localparam logic [BYTE_W-1:0] BAD_LO   = 8'hFE;

  // Input transaction
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_marker;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [CHAR_W-1:0] char_bytes;
    logic [LEN_W-1:0]  char_length;
    logic              error;
    logic [LEN_W-1:0]  consumed_count;
  } out_t;

  // Sequence length announced by a lead byte (0xC0..0xFF)
  function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] len;
    if (b < LEAD3_LO) begin
      len = LEN_W'(2);
    end else if (b < LEAD4_LO) begin
      len = LEN_W'(3);
    end else if (b < LEAD5_LO) begin
      len = LEN_W'(4);
    end else if (b < LEAD6_LO) begin
      len = LEN_W'(5);
    end else begin
      len = LEN_W'(6);
    end
    return len;
  endfunction

endpackage

/* sv/uca_in_stage.sv */
module uca_in_stage
  import uca_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_item,
  input  logic advance,
  output logic fire,
  output in_t  item
);

  logic in_valid_r, in_valid_nxt;
  in_t  item_r;
  logic load;

  // Register takes a new transaction when empty or draining this cycle
  assign in_stall = in_valid_r && !advance;
  assign load     = in_valid && !in_stall;
  assign fire     = in_valid_r && advance;
  assign item     = item_r;

  always_comb begin
    if (load) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

endmodule

/* sv/uca_framer.sv */
module uca_framer
  import uca_pkg::*;
#(
  parameter int unsigned MAX_SEQ_LEN = MAX_SEQ_LEN_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  in_t  item,
  output logic res_valid,
  output out_t res
);

  localparam int unsigned HELD_N = MAX_SEQ_LEN - 1;

  logic [POS_W-1:0]  position_r, position_nxt;
  logic [LEN_W-1:0]  exp_len_r, exp_len_nxt;
  logic [BYTE_W-1:0] held_r [HELD_N];

  logic [BYTE_W-1:0] b;
  logic              is_cont;
  logic [LEN_W-1:0]  lead_len;
  logic              held_we;
  logic [CHAR_W-1:0] acc;

  assign b        = item.data_byte;
  assign is_cont  = (b >= CONT_LO) && (b < LEAD_LO);
  assign lead_len = lead_length(b);

  // Assemble held bytes below the current position plus the new byte at it
  always_comb begin
    acc = '0;
    for (int i = 0; i < MAX_SEQ_LEN; i++) begin
      if (POS_W'(i) == position_r) begin
        acc[i*BYTE_W +: BYTE_W] = b;
      end else if (i < HELD_N && POS_W'(i) < position_r) begin
        acc[i*BYTE_W +: BYTE_W] = held_r[(i < HELD_N) ? i : 0];
      end
    end
  end

  // Framing decision and state update
  always_comb begin
    position_nxt = position_r;
    exp_len_nxt  = exp_len_r;
    held_we      = 1'b0;
    res_valid    = 1'b0;
    res          = '0;
    if (fire) begin
      if (item.end_marker) begin
        // end of stream closes an open sequence as truncated
        if (position_r != '0) begin
          res_valid          = 1'b1;
          res.error          = 1'b1;
          res.consumed_count = LEN_W'(position_r);
          position_nxt       = '0;
          exp_len_nxt        = '0;
        end
      end else if (position_r == '0) begin
        if (b < CONT_LO) begin
          res_valid          = 1'b1;
          res.char_bytes     = CHAR_W'(b);
          res.char_length    = LEN_W'(1);
          res.consumed_count = LEN_W'(1);
        end else if (is_cont || b >= BAD_LO || lead_len > LEN_W'(MAX_SEQ_LEN)) begin
          res_valid          = 1'b1;
          res.error          = 1'b1;
          res.consumed_count = LEN_W'(1);
        end else begin
          held_we      = 1'b1;
          exp_len_nxt  = lead_len;
          position_nxt = POS_W'(1);
        end
      end else if (!is_cont) begin
        // interrupted sequence: offending byte goes with the failed character
        res_valid          = 1'b1;
        res.error          = 1'b1;
        res.consumed_count = LEN_W'(position_r + POS_W'(1));
        position_nxt       = '0;
        exp_len_nxt        = '0;
      end else if (LEN_W'(position_r + POS_W'(1)) >= exp_len_r) begin
        res_valid          = 1'b1;
        res.char_bytes     = acc;
        res.char_length    = LEN_W'(position_r + POS_W'(1));
        res.consumed_count = LEN_W'(position_r + POS_W'(1));
        position_nxt       = '0;
        exp_len_nxt        = '0;
      end else begin
        held_we      = 1'b1;
        position_nxt = position_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      exp_len_r  <= '0;
    end else begin
      position_r <= position_nxt;
      exp_len_r  <= exp_len_nxt;
    end
  end

  // Held bytes, written at the current position
  always_ff @(posedge clk) begin
    for (int i = 0; i < HELD_N; i++) begin
      if (held_we && POS_W'(i) == position_r) begin
        held_r[i] <= b;
      end
    end
  end

  // An open sequence never reaches its announced length
  a_pos_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    position_r != '0 |-> position_r < POS_W'(exp_len_r))
    else $error("position reached expected length");

  // Idle means no length pending
  a_idle_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    position_r == '0 |-> exp_len_r == '0)
    else $error("expected length left over while idle");

  // A good character is consumed exactly as long as it is
  a_good_len: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.error |-> res.char_length == res.consumed_count)
    else $error("character length differs from consumed count");

  // Any result, character or error, leaves the framer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> position_r == '0)
    else $error("framer not idle after a result");

endmodule

/* sv/uca_out_stage.sv */
module uca_out_stage
  import uca_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic res_valid,
  input  out_t res,
  output logic advance,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_item
);

  logic out_valid_r, out_valid_nxt;
  out_t out_r;
  logic load;

  // Pipeline moves when the result register is empty or being taken
  assign advance       = !out_valid_r || !out_stall;
  assign load          = advance && res_valid;
  assign out_valid_nxt = advance ? res_valid : out_valid_r;
  assign out_valid     = out_valid_r;
  assign out_item      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

endmodule

/* sv/utf8_char_assembler.sv */
// UTF-8 character assembler: frames a byte stream into characters of 1 to
// MAX_SEQ_LEN bytes (six-byte form) and reports each finished character with
// its raw bytes, its length and the stream bytes consumed, or an error for
// malformed or truncated sequences. One byte is accepted every clock cycle
// while results are being taken; out_stall reaches in_stall through the same
// cycle, so only a held result stops the input. A transaction passes an input
// register, combinational framing logic and a result register: the result of
// its last byte is framed from the input register and loaded into the result
// register, where it is presented until taken. With the receiver stalled the
// block holds one byte and one result. Bytes that only extend an open
// sequence produce no result.
module utf8_char_assembler
  import uca_pkg::*;
#(
  parameter int unsigned MAX_SEQ_LEN = MAX_SEQ_LEN_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_item,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_item
);

  logic advance;
  logic fire;
  in_t  item;
  logic res_valid;
  out_t res;

  // Input register
  uca_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .fire     (fire),
    .item     (item)
  );

  // Framing logic and sequence state
  uca_framer #(
    .MAX_SEQ_LEN (MAX_SEQ_LEN)
  ) u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  uca_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import uca_pkg::*;

  localparam int MAX_SEQ     = MAX_SEQ_LEN_DEF;
  localparam int DIR_N       = 26;
  localparam int PHASE_ITEMS = 450;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 16;

  // How a directed row is checked: by the predictor, no result, or a typed result
  typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_RES} row_chk_t;

  typedef struct packed {
    in_t      item;
    row_chk_t chk;
    out_t     res;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_item   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_item;

  // Predictor state: open sequence position, announced length, held bytes
  logic [2:0] seq_pos = '0;
  logic [2:0] seq_len = '0;
  logic [7:0] held [MAX_SEQ-1];

  out_t pending_chars [$];
  out_t want_char;
  int   mismatch_cnt = 0;
  int   bytes_taken  = 0;
  int   tx_idle_pct  = 0;
  int   rx_idle_pct  = 0;
  bit   hold_req     = 1'b0;
  bit   hold_ack     = 1'b0;
  int   hold_left    = 0;

  // Directed stimulus: {data_byte, end_marker, check, char_bytes, length, error, consumed}
  dir_row_t dir_rows [DIR_N] = '{
    {8'h00, 1'b0, ROW_RES,  48'h00, 3'd1, 1'b0, 3'd1},  // lowest ASCII
    {8'h7F, 1'b0, ROW_RES,  48'h7F, 3'd1, 1'b0, 3'd1},  // highest ASCII
    {8'h80, 1'b0, ROW_RES,  48'h00, 3'd0, 1'b1, 3'd1},  // continuation first
    {8'hBF, 1'b0, ROW_RES,  48'h00, 3'd0, 1'b1, 3'd1},
    {8'hFE, 1'b0, ROW_RES,  48'h00, 3'd0, 1'b1, 3'd1},  // invalid bytes
    {8'hFF, 1'b0, ROW_RES,  48'h00, 3'd0, 1'b1, 3'd1},
    {8'hA5, 1'b1, ROW_NONE, 48'h00, 3'd0, 1'b0, 3'd0},  // end of stream while idle
    {8'hC0, 1'b0, ROW_PRED, 48'h00, 3'd0, 1'b0, 3'd0},  // two-byte chars
    {8'h80, 1'b0, ROW_PRED, 48'h00, 3'd0, 1'b0, 3'd0},
    {8'hDF, 1'b0, ROW_PRED, 48'h00, 3'd0, 1'b0, 3'd0},
    {8'hBF, 1'b0, ROW_PRED, 48'h00, 3'd0, 1'b0, 3'd0},
    {8'hE0, 1'b0, ROW_PRED, 48'h00, 3'd0, 1'b0, 3'd0},  // three-byte char
    {8'h80, 1'b0, ROW_PRED, 48'h00, 3'd0, 1'b0, 3'd0},
    {8'hBF, 1'b0, ROW_PRED, 48'h00, 3'd0, 1'b0, 3'd0},
    {8'hF7, 1'b0, ROW_PRED, 48'h00, 3'd0, 1'b0, 3'd0},  // four-byte lead, then cut by ASCII
    {8'h9A, 1'b0, ROW_PRED, 48'h00, 3'd0, 1'b0, 3'd0},
    {8'h41, 1'b0, ROW_RES,  48'h00, 3'd0, 1'b1, 3'd3},
    {8'hFD, 1'b0, ROW_PRED, 48'h00, 3'd0, 1'b0, 3'd0},  // full six-byte char
    {8'h80, 1'b0, ROW_PRED, 48'h00, 3'd0, 1'b0, 3'd0},
    {8'h81, 1'b0, ROW_PRED, 48'h00, 3'd0, 1'b0, 3'd0},
    {8'hBF, 1'b0, ROW_PRED, 48'h00, 3'd0, 1'b0, 3'd0},
    {8'hA5, 1'b0, ROW_PRED, 48'h00, 3'd0, 1'b0, 3'd0},
    {8'h80, 1'b0, ROW_PRED, 48'h00, 3'd0, 1'b0, 3'd0},
    {8'hFB, 1'b0, ROW_PRED, 48'h00, 3'd0, 1'b0, 3'd0},  // five-byte lead cut by end of stream
    {8'h80, 1'b0, ROW_PRED, 48'h00, 3'd0, 1'b0, 3'd0},
    {8'h00, 1'b1, ROW_RES,  48'h00, 3'd0, 1'b1, 3'd2}
  };

  utf8_char_assembler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Frame one accepted byte; returns the finished character or error, if any
  function automatic void frame_byte(input in_t it, output bit has, output out_t res);
    logic [7:0] b;
    bit         is_cont;
    int         ones;
    int         n;
    b       = it.data_byte;
    is_cont = (b[7:6] == 2'b10);
    has     = 1'b0;
    res     = '0;
    ones    = 0;
    // leading ones give the announced length
    while (ones < 8 && b[7-ones]) ones++;
    if (it.end_marker) begin
      if (seq_pos != 0) begin
        has = 1'b1;
        res.error = 1'b1;
        res.consumed_count = seq_pos;
        seq_pos = '0;
        seq_len = '0;
      end
    end else if (seq_pos == 0) begin
      if (ones == 0) begin
        has = 1'b1;
        res.char_bytes = CHAR_W'(b);
        res.char_length = 3'd1;
        res.consumed_count = 3'd1;
      end else if (is_cont || b >= BAD_LO || ones > MAX_SEQ) begin
        has = 1'b1;
        res.error = 1'b1;
        res.consumed_count = 3'd1;
      end else begin
        held[0] = b;
        seq_len = 3'(ones);
        seq_pos = 3'd1;
      end
    end else if (!is_cont) begin
      // offending byte goes down with the open sequence
      has = 1'b1;
      res.error = 1'b1;
      res.consumed_count = 3'(seq_pos + 1);
      seq_pos = '0;
      seq_len = '0;
    end else if (seq_pos + 1 >= seq_len) begin
      n = (seq_pos > MAX_SEQ - 1) ? MAX_SEQ - 1 : int'(seq_pos);
      for (int i = 0; i < n; i++) res.char_bytes[8*i +: 8] = held[i];
      res.char_bytes[8*n +: 8] = b;
      has = 1'b1;
      res.char_length = 3'(n + 1);
      res.consumed_count = 3'(n + 1);
      seq_pos = '0;
      seq_len = '0;
    end else begin
      if (seq_pos < MAX_SEQ - 1) held[seq_pos] = b;
      seq_pos = seq_pos + 3'd1;
    end
  endfunction

  // Offer one input transaction, wait for acceptance, record what it should produce
  task automatic send_byte(input in_t it, input row_chk_t chk, input out_t typed);
    bit   has;
    out_t res;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (!(it.end_marker && seq_pos == 0)) bytes_taken++;
    frame_byte(it, has, res);
    if (chk == ROW_RES) pending_chars.push_back(typed);
    else if (chk == ROW_PRED && has) pending_chars.push_back(res);
  endtask

  // Sender goes quiet until every expected character is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  // One random stretch: mostly well-formed chars, some broken or stray bytes
  task automatic send_char_seq();
    int         kind;
    int         len;
    int         k;
    logic [7:0] b;
    in_t        it;
    kind = $urandom_range(0, 99);
    it.end_marker = 1'b0;
    if (kind < 40) begin
      it.data_byte = 8'($urandom_range(0, 127));
      send_byte(it, ROW_PRED, '0);
    end else if (kind < 94) begin
      len = $urandom_range(2, MAX_SEQ);
      it.data_byte = 8'((8'hFF << (8 - len)) | ($urandom & (8'hFF >> (len + 1))));
      send_byte(it, ROW_PRED, '0);
      k = (kind < 80) ? len - 1 : $urandom_range(0, len - 2);
      repeat (k) begin
        it.data_byte = 8'h80 | 8'($urandom_range(0, 63));
        send_byte(it, ROW_PRED, '0);
      end
      if (kind >= 80 && kind < 88) begin
        // truncated by end of stream
        it.end_marker = 1'b1;
        it.data_byte = 8'($urandom);
        send_byte(it, ROW_PRED, '0);
      end else if (kind >= 88) begin
        // interrupted by anything but a continuation
        do b = 8'($urandom); while (b[7:6] == 2'b10);
        it.data_byte = b;
        send_byte(it, ROW_PRED, '0);
      end
    end else if (kind < 98) begin
      it.data_byte = $urandom_range(0, 1) ? (8'h80 | 8'($urandom_range(0, 63)))
                                          : (8'hFE | 8'($urandom_range(0, 1)));
      send_byte(it, ROW_PRED, '0);
    end else begin
      it.end_marker = 1'b1;
      it.data_byte = 8'($urandom);
      send_byte(it, ROW_PRED, '0);
    end
  endtask

  // Result side: check each accepted transaction, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: result expected none got %h", $time, out_item);
        mismatch_cnt++;
      end else begin
        want_char = pending_chars.pop_front();
        if (out_item.char_bytes !== want_char.char_bytes) begin
          $display("%0t: char_bytes expected %h got %h", $time, want_char.char_bytes,
                   out_item.char_bytes);
          mismatch_cnt++;
        end
        if (out_item.char_length !== want_char.char_length) begin
          $display("%0t: char_length expected %0d got %0d", $time, want_char.char_length,
                   out_item.char_length);
          mismatch_cnt++;
        end
        if (out_item.error !== want_char.error) begin
          $display("%0t: error expected %b got %b", $time, want_char.error, out_item.error);
          mismatch_cnt++;
        end
        if (out_item.consumed_count !== want_char.consumed_count) begin
          $display("%0t: consumed_count expected %0d got %0d", $time,
                   want_char.consumed_count, out_item.consumed_count);
          mismatch_cnt++;
        end
      end
    end
    // long hold-off on request, else random stall
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Main sequence
  initial begin
    int phase_end;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    for (int i = 0; i < DIR_N; i++) begin
      send_byte(dir_rows[i].item, dir_rows[i].chk, dir_rows[i].res);
    end
    wait_drained();

    // random phases: light sender idling, then heavy, then none
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 78 : 0;
      rx_idle_pct <= (ph == 0) ? 78 : (ph == 1) ? 13 : 0;
      if (ph == 2) hold_req <= ~hold_req;
      phase_end = bytes_taken + PHASE_ITEMS;
      while (bytes_taken < phase_end) send_char_seq();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_chars.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule
